>>> hdl/ipgp_pkg.sv
// ----------------------------------------------------------------------------
// ipgp_pkg
// shared types and constants of the pixel get/put unit
// ----------------------------------------------------------------------------
package ipgp_pkg;

    // image store geometry
    localparam int STORE_BYTES = 65536;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int MAX_DIM     = 4096;
    localparam int MAX_PLANES  = 32;

    // datapath widths
    localparam int ROW_W  = 28;   // line_bytes * y
    localparam int SLAB_W = 29;   // line_bytes * height
    localparam int ADDR_W = 30;   // row plus column offset
    localparam int SPAN_W = 34;   // slab * (planes - 1)
    localparam int SUM_W  = 35;   // span plus base
    localparam int OFF_W  = 14;   // column byte offset
    localparam int CNT_W  = 6;    // access count, up to MAX_PLANES
    localparam int IDX_W  = 5;    // access index

    // register map, word index
    localparam logic [2:0] REG_FORMAT      = 3'd0;
    localparam logic [2:0] REG_PIXEL_SIZE  = 3'd1;
    localparam logic [2:0] REG_LINE_BYTES  = 3'd2;
    localparam logic [2:0] REG_WIDTH       = 3'd3;
    localparam logic [2:0] REG_HEIGHT      = 3'd4;
    localparam logic [2:0] REG_MSB_FIRST   = 3'd5;
    localparam logic [2:0] REG_PLANE_COUNT = 3'd6;

    // image format codes
    localparam logic [1:0] FMT_PACKED = 2'd0;
    localparam logic [1:0] FMT_BITMAP = 2'd1;
    localparam logic [1:0] FMT_PLANES = 2'd2;

    // packed pixel size codes
    localparam logic [1:0] PSZ_1  = 2'd0;
    localparam logic [1:0] PSZ_8  = 2'd1;
    localparam logic [1:0] PSZ_16 = 2'd2;
    localparam logic [1:0] PSZ_32 = 2'd3;

    typedef struct packed {
        logic [1:0]  image_format;
        logic [1:0]  pixel_size_code;
        logic [15:0] line_bytes;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        msb_first;
        logic [5:0]  plane_count;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [31:0] pixel_value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        ok;
    } rsp_t;

endpackage

>>> hdl/ipgp_ram.sv
// ----------------------------------------------------------------------------
// ipgp_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ipgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ipgp_cfg.sv
// ----------------------------------------------------------------------------
// ipgp_cfg
// configuration register file behind the apb port
// ----------------------------------------------------------------------------
module ipgp_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [2:0]          idx,
    input  logic [31:0]         wdata,
    output logic [31:0]         rdata,
    output ipgp_pkg::cfg_t      cfg
);

    ipgp_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_format    <= ipgp_pkg::FMT_PACKED;
            cfg_reg.pixel_size_code <= ipgp_pkg::PSZ_32;
            cfg_reg.line_bytes      <= '0;
            cfg_reg.image_width     <= '0;
            cfg_reg.image_height    <= '0;
            cfg_reg.msb_first       <= 1'b0;
            cfg_reg.plane_count     <= 6'd1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ipgp_pkg::REG_FORMAT:      cfg_reg.image_format    <= wdata[1:0];
                ipgp_pkg::REG_PIXEL_SIZE:  cfg_reg.pixel_size_code <= wdata[1:0];
                ipgp_pkg::REG_LINE_BYTES:  cfg_reg.line_bytes      <= wdata[15:0];
                ipgp_pkg::REG_WIDTH:       cfg_reg.image_width     <= wdata[12:0];
                ipgp_pkg::REG_HEIGHT:      cfg_reg.image_height    <= wdata[12:0];
                ipgp_pkg::REG_MSB_FIRST:   cfg_reg.msb_first       <= wdata[0];
                ipgp_pkg::REG_PLANE_COUNT: cfg_reg.plane_count     <= wdata[5:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ipgp_pkg::REG_FORMAT:      rdata = {30'd0, cfg_reg.image_format};
            ipgp_pkg::REG_PIXEL_SIZE:  rdata = {30'd0, cfg_reg.pixel_size_code};
            ipgp_pkg::REG_LINE_BYTES:  rdata = {16'd0, cfg_reg.line_bytes};
            ipgp_pkg::REG_WIDTH:       rdata = {19'd0, cfg_reg.image_width};
            ipgp_pkg::REG_HEIGHT:      rdata = {19'd0, cfg_reg.image_height};
            ipgp_pkg::REG_MSB_FIRST:   rdata = {31'd0, cfg_reg.msb_first};
            ipgp_pkg::REG_PLANE_COUNT: rdata = {26'd0, cfg_reg.plane_count};
            default:                   rdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/image_pixel_get_put.sv
// ----------------------------------------------------------------------------
// image_pixel_get_put
// pixel read/write unit over a 64 KiB byte-addressed image store
// ----------------------------------------------------------------------------
// usage
//   the image layout is programmed over the apb port while no transaction is
//   in flight; registers sit at byte address 4*i, pready is always high
//   a request transaction (req, req_valid/req_stall) reads or writes the
//   pixel at (pos_x, pos_y); each request yields exactly one response
//   transaction (rsp, rsp_valid/rsp_stall) carrying read_value and ok
//   one request is worked on at a time: after acceptance, the states S_ROW,
//   S_ADDR, S_PMUL and S_CHECK compute the row, column and plane addresses
//   and check bounds, then the read-modify-write loop makes N byte accesses
//   to the store, with N = 1 (bitmap or one-bit pixels), 1/2/4 (packed
//   bytes) or the plane count (bit-planes); a refused request goes from the
//   bounds check straight to the final state that raises rsp_valid; the loop
//   is paced by the one byte access per cycle of the store port
//   the response register lets the next request be accepted while a result
//   waits; a stalled receiver only holds the unit in its final state
//   after reset the whole store is cleared one byte a cycle, during which
//   req_stall stays high; configuration writes are taken meanwhile
// ----------------------------------------------------------------------------
module image_pixel_get_put (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // requests
    input  logic                  req_valid,
    output logic                  req_stall,
    input  ipgp_pkg::req_t        req,
    // responses
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ipgp_pkg::rsp_t        rsp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROW,
        S_ADDR,
        S_PMUL,
        S_CHECK,
        S_ACCESS,
        S_DONE
    } state_t;

    // how the pixel maps onto store bytes
    typedef enum logic [1:0] {
        M_BIT,
        M_BYTES,
        M_PLANE,
        M_NONE
    } mode_t;

    localparam int AW = ipgp_pkg::STORE_AW;

    ipgp_pkg::cfg_t cfg;
    logic           cfg_wr;

    // store port
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    // control and datapath registers
    state_t                            state_reg,    state_next;
    logic [AW-1:0]                     clr_addr_reg, clr_addr_next;
    ipgp_pkg::req_t                    req_reg,      req_next;
    mode_t                             mode_reg,     mode_next;
    logic                              inside_reg,   inside_next;
    logic [7:0]                        mask_reg,     mask_next;
    logic [ipgp_pkg::CNT_W-1:0]        total_reg,    total_next;
    logic [ipgp_pkg::ROW_W-1:0]        row_reg,      row_next;
    logic [ipgp_pkg::ADDR_W-1:0]       base_reg,     base_next;
    logic [ipgp_pkg::ADDR_W-1:0]       last_reg,     last_next;
    logic [ipgp_pkg::SLAB_W-1:0]       slab_reg,     slab_next;
    logic [ipgp_pkg::SPAN_W-1:0]       span_reg,     span_next;
    logic [AW-1:0]                     rd_addr_reg,  rd_addr_next;
    logic [AW-1:0]                     step_reg,     step_next;
    logic [ipgp_pkg::CNT_W-1:0]        issued_reg,   issued_next;
    logic                              pend_reg,     pend_next;
    logic [ipgp_pkg::IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic [AW-1:0]                     wr_addr_reg,  wr_addr_next;
    logic                              fwd_reg,      fwd_next;
    logic [7:0]                        fwd_data_reg, fwd_data_next;
    logic [31:0]                       acc_reg,      acc_next;
    logic                              ok_reg,       ok_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    ipgp_pkg::rsp_t                    rsp_reg,      rsp_next;

    // combinational helpers
    logic [2:0]                        bit_pos;
    logic [ipgp_pkg::OFF_W-1:0]        col_off;
    logic [5:0]                        planes;
    logic [ipgp_pkg::SUM_W-1:0]        plane_last;
    logic                              issue;
    logic [7:0]                        old_byte;
    logic [7:0]                        new_byte;
    logic                              old_bit;
    logic                              set_bit;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    ipgp_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr),
        .idx   (paddr[4:2]),
        .wdata (pwdata),
        .rdata (prdata),
        .cfg   (cfg)
    );

    // ------------------------------------------------------------------------
    // image store
    // ------------------------------------------------------------------------
    ipgp_ram #(
        .WIDTH (8),
        .DEPTH (ipgp_pkg::STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // bit inside a byte, by configured bit order
    assign bit_pos = cfg.msb_first ? (3'd7 - req_reg.pos_x[2:0]) : req_reg.pos_x[2:0];

    // planes in use, clamped
    assign planes = (cfg.plane_count > 6'(ipgp_pkg::MAX_PLANES))
                    ? 6'(ipgp_pkg::MAX_PLANES) : cfg.plane_count;

    // last byte touched by the plane walk
    assign plane_last = ipgp_pkg::SUM_W'(span_reg) + ipgp_pkg::SUM_W'(base_reg);

    // column byte offset inside the row
    always_comb
    begin
        col_off = ipgp_pkg::OFF_W'(req_reg.pos_x[11:3]);
        if (mode_reg == M_BYTES)
        begin
            case (cfg.pixel_size_code)
                ipgp_pkg::PSZ_16: col_off = ipgp_pkg::OFF_W'({req_reg.pos_x, 1'b0});
                ipgp_pkg::PSZ_32: col_off = ipgp_pkg::OFF_W'({req_reg.pos_x, 2'b00});
                default:          col_off = ipgp_pkg::OFF_W'(req_reg.pos_x);
            endcase
        end
    end

    // byte read back this cycle, forwarded when the previous write hit it
    assign old_byte = fwd_reg ? fwd_data_reg : ram_rdata;
    assign old_bit  = |(old_byte & mask_reg);
    assign set_bit  = (mode_reg == M_PLANE) ? req_reg.pixel_value[pend_idx_reg]
                                            : |req_reg.pixel_value;
    assign issue    = (issued_reg != total_reg);

    always_comb
    begin
        if (mode_reg == M_BYTES)
        begin
            new_byte = req_reg.pixel_value[{pend_idx_reg[1:0], 3'b000} +: 8];
        end
        else if (set_bit)
        begin
            new_byte = old_byte | mask_reg;
        end
        else
        begin
            new_byte = old_byte & ~mask_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        req_next       = req_reg;
        mode_next      = mode_reg;
        inside_next    = inside_reg;
        mask_next      = mask_reg;
        total_next     = total_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        last_next      = last_reg;
        slab_next      = slab_reg;
        span_next      = span_reg;
        rd_addr_next   = rd_addr_reg;
        step_next      = step_reg;
        issued_next    = issued_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        wr_addr_next   = wr_addr_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        acc_next       = acc_reg;
        ok_next        = ok_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = new_byte;
        ram_raddr = rd_addr_reg;

        // response register drains independently
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero the store one byte a cycle
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = 8'd0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_ROW;
                end
            end

            S_ROW:
            begin
                row_next = ipgp_pkg::ROW_W'(cfg.line_bytes) * ipgp_pkg::ROW_W'(req_reg.pos_y);
                inside_next = ({1'b0, req_reg.pos_x} < cfg.image_width)
                           && ({1'b0, req_reg.pos_y} < cfg.image_height);
                mask_next = 8'd1 << bit_pos;
                unique case (cfg.image_format)
                    ipgp_pkg::FMT_PACKED:
                    begin
                        if (cfg.pixel_size_code == ipgp_pkg::PSZ_1)
                        begin
                            mode_next  = M_BIT;
                            total_next = ipgp_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            mode_next = M_BYTES;
                            case (cfg.pixel_size_code)
                                ipgp_pkg::PSZ_8:  total_next = ipgp_pkg::CNT_W'(1);
                                ipgp_pkg::PSZ_16: total_next = ipgp_pkg::CNT_W'(2);
                                default:          total_next = ipgp_pkg::CNT_W'(4);
                            endcase
                        end
                    end
                    ipgp_pkg::FMT_BITMAP:
                    begin
                        mode_next  = M_BIT;
                        total_next = ipgp_pkg::CNT_W'(1);
                    end
                    ipgp_pkg::FMT_PLANES:
                    begin
                        mode_next  = M_PLANE;
                        total_next = planes;
                    end
                    default:
                    begin
                        mode_next  = M_NONE;
                        total_next = '0;
                    end
                endcase
                state_next = S_ADDR;
            end

            S_ADDR:
            begin
                base_next = ipgp_pkg::ADDR_W'(row_reg) + ipgp_pkg::ADDR_W'(col_off);
                last_next = ipgp_pkg::ADDR_W'(row_reg) + ipgp_pkg::ADDR_W'(col_off)
                          + ipgp_pkg::ADDR_W'(total_reg) - 1'b1;
                slab_next = ipgp_pkg::SLAB_W'(cfg.line_bytes)
                          * ipgp_pkg::SLAB_W'(cfg.image_height);
                state_next = S_PMUL;
            end

            S_PMUL:
            begin
                // offset of the last plane's byte
                span_next = ipgp_pkg::SPAN_W'(slab_reg)
                          * ipgp_pkg::SPAN_W'(ipgp_pkg::IDX_W'(total_reg - 1'b1));
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                acc_next      = '0;
                ok_next       = 1'b0;
                issued_next   = '0;
                pend_next     = 1'b0;
                fwd_next      = 1'b0;
                rd_addr_next  = base_reg[AW-1:0];
                step_next     = (mode_reg == M_PLANE) ? slab_reg[AW-1:0] : AW'(1);
                state_next    = S_DONE;
                if (inside_reg)
                begin
                    unique case (mode_reg)
                        M_BIT, M_BYTES:
                        begin
                            if (last_reg < ipgp_pkg::ADDR_W'(ipgp_pkg::STORE_BYTES))
                            begin
                                ok_next    = 1'b1;
                                state_next = S_ACCESS;
                            end
                        end
                        M_PLANE:
                        begin
                            // zero planes succeed with nothing touched
                            if (total_reg == '0)
                            begin
                                ok_next = 1'b1;
                            end
                            else if (plane_last < ipgp_pkg::SUM_W'(ipgp_pkg::STORE_BYTES))
                            begin
                                ok_next    = 1'b1;
                                state_next = S_ACCESS;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end

            S_ACCESS:
            begin
                // read stage: one byte address per cycle
                pend_next     = issue;
                pend_idx_next = ipgp_pkg::IDX_W'(issued_reg);
                wr_addr_next  = rd_addr_reg;
                fwd_next      = 1'b0;
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + step_reg;
                    issued_next  = issued_reg + 1'b1;
                end

                // modify and write back stage
                if (pend_reg)
                begin
                    unique case (mode_reg)
                        M_BYTES: acc_next[{pend_idx_reg[1:0], 3'b000} +: 8] = old_byte;
                        M_PLANE: acc_next[pend_idx_reg] = old_bit;
                        default: acc_next = {31'd0, old_bit};
                    endcase
                    if (req_reg.action)
                    begin
                        ram_we = 1'b1;
                        // same byte read this cycle sees the new value next cycle
                        fwd_next      = issue && (rd_addr_reg == wr_addr_reg);
                        fwd_data_next = new_byte;
                    end
                    if (pend_idx_reg == ipgp_pkg::IDX_W'(total_reg - 1'b1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.ok         = ok_reg;
                    rsp_next.read_value = (ok_reg && !req_reg.action) ? acc_reg : 32'd0;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            req_reg       <= '0;
            mode_reg      <= M_NONE;
            inside_reg    <= 1'b0;
            mask_reg      <= '0;
            total_reg     <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            last_reg      <= '0;
            slab_reg      <= '0;
            span_reg      <= '0;
            rd_addr_reg   <= '0;
            step_reg      <= '0;
            issued_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            wr_addr_reg   <= '0;
            fwd_reg       <= 1'b0;
            fwd_data_reg  <= '0;
            acc_reg       <= '0;
            ok_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            req_reg       <= req_next;
            mode_reg      <= mode_next;
            inside_reg    <= inside_next;
            mask_reg      <= mask_next;
            total_reg     <= total_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            last_reg      <= last_next;
            slab_reg      <= slab_next;
            span_reg      <= span_next;
            rd_addr_reg   <= rd_addr_next;
            step_reg      <= step_next;
            issued_reg    <= issued_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            wr_addr_reg   <= wr_addr_next;
            fwd_reg       <= fwd_next;
            fwd_data_reg  <= fwd_data_next;
            acc_reg       <= acc_next;
            ok_reg        <= ok_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

`ifndef NO_ASSERTIONS
    // the store is only written by the clearing pass or a write request
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR) || (state_reg == S_ACCESS && req_reg.action))
        else $error("store written outside a write access");

    // the access loop never issues more reads than the pixel needs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACCESS) |-> (issued_reg <= total_reg))
        else $error("access loop overran its count");

    // a new response only comes from the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(state_reg) == S_DONE))
        else $error("response raised outside the final state");

    // refused requests report a zero pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ok) |-> (rsp.read_value == 32'd0))
        else $error("refused request carries a pixel value");
`endif

endmodule

>>> tb/image_pixel_get_put_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_pixel_get_put_tb
// self-checking bench for the pixel get/put unit: a mirror of the image store
// and layout registers predicts every response, directed layouts cover the
// edge cases, then randomized layouts and traffic run under random idling,
// including one long response hold-off that fills the unit
// ----------------------------------------------------------------------------
module image_pixel_get_put_tb;

    // codes the package leaves out
    localparam logic       ACT_READ   = 1'b0;
    localparam logic       ACT_WRITE  = 1'b1;
    localparam logic [1:0] FMT_UNUSED = 2'd3;

    // the watchdog limit outlasts the reset clearing pass, during which nothing is accepted
    localparam int WATCHDOG_CYCLES = 200000;
    localparam int TAIL_CYCLES     = 60;

    // clock, reset and block ports, all known from time zero
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             psel      = 1'b0;
    logic             penable   = 1'b0;
    logic             pwrite    = 1'b0;
    logic [4:0]       paddr     = '0;
    logic [31:0]      pwdata    = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             req_valid = 1'b0;
    logic             req_stall;
    ipgp_pkg::req_t   req       = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    ipgp_pkg::rsp_t   rsp;

    // mirror of the unit: layout registers and the byte store
    ipgp_pkg::cfg_t   layout;
    logic [7:0]       image_mem [0:ipgp_pkg::STORE_BYTES-1];

    // responses predicted at request acceptance, oldest first
    ipgp_pkg::rsp_t   expected_rsp [$];

    // idling controls, set per phase by the tests
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int          hold_len = 0;     // request for one long receiver hold-off

    // bookkeeping
    int          mismatches  = 0;
    int          n_items     = 0;
    int          n_writes    = 0;
    int          n_refused   = 0;
    int          n_checked   = 0;
    int          n_layouts   = 0;
    int          n_by_format [4] = '{0, 0, 0, 0};
    int          idle_cycles = 0;

    image_pixel_get_put u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // checking helper
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // read one pixel bit and optionally set or clear it
    function automatic logic store_bit_rmw(longint unsigned addr, logic [11:0] x,
                                           logic wr, logic set);
        logic [2:0] bit_pos;
        logic [7:0] mask;
        logic       old;
        bit_pos = layout.msb_first ? 3'd7 - x[2:0] : x[2:0];
        mask    = 8'd1 << bit_pos;
        old     = |(image_mem[addr] & mask);
        if (wr)
        begin
            image_mem[addr] = set ? (image_mem[addr] | mask) : (image_mem[addr] & ~mask);
        end
        return old;
    endfunction

    // response of the unit to one request, updating the mirrored store
    function automatic ipgp_pkg::rsp_t predict_pixel(ipgp_pkg::req_t item);
        longint unsigned wlim, hlim, row, addr, nb, slab, nplanes;
        logic [31:0]     rd;
        logic            done;
        logic            wr;
        ipgp_pkg::rsp_t  res;
        wlim = (layout.image_width  < ipgp_pkg::MAX_DIM) ? 64'(layout.image_width)
                                                          : 64'(ipgp_pkg::MAX_DIM);
        hlim = (layout.image_height < ipgp_pkg::MAX_DIM) ? 64'(layout.image_height)
                                                          : 64'(ipgp_pkg::MAX_DIM);
        row  = 64'(layout.line_bytes) * 64'(item.pos_y);
        wr   = (item.action == ACT_WRITE);
        rd   = '0;
        done = 1'b0;
        if (64'(item.pos_x) < wlim && 64'(item.pos_y) < hlim)
        begin
            if (layout.image_format == ipgp_pkg::FMT_BITMAP ||
                (layout.image_format == ipgp_pkg::FMT_PACKED &&
                 layout.pixel_size_code == ipgp_pkg::PSZ_1))
            begin
                addr = row + 64'(item.pos_x[11:3]);
                if (addr < 64'(ipgp_pkg::STORE_BYTES))
                begin
                    rd[0] = store_bit_rmw(addr, item.pos_x, wr, item.pixel_value != 0);
                    done  = 1'b1;
                end
            end
            else if (layout.image_format == ipgp_pkg::FMT_PACKED)
            begin
                nb   = (layout.pixel_size_code == ipgp_pkg::PSZ_8)  ? 64'd1 :
                       (layout.pixel_size_code == ipgp_pkg::PSZ_16) ? 64'd2 : 64'd4;
                addr = row + nb * 64'(item.pos_x);
                // little-endian bytes, narrow writes keep the low bytes only
                if (addr + nb - 1 < 64'(ipgp_pkg::STORE_BYTES))
                begin
                    for (int i = 0; i < int'(nb); i++)
                    begin
                        rd |= 32'(image_mem[addr + 64'(i)]) << (8 * i);
                        if (wr)
                        begin
                            image_mem[addr + 64'(i)] = item.pixel_value[8 * i +: 8];
                        end
                    end
                    done = 1'b1;
                end
            end
            else if (layout.image_format == ipgp_pkg::FMT_PLANES)
            begin
                nplanes = (layout.plane_count < ipgp_pkg::MAX_PLANES)
                          ? 64'(layout.plane_count) : 64'(ipgp_pkg::MAX_PLANES);
                slab    = 64'(layout.line_bytes) * 64'(layout.image_height);
                addr    = row + 64'(item.pos_x[11:3]);
                if (nplanes == 0)
                begin
                    done = 1'b1;
                end
                else if (slab * (nplanes - 1) + addr < 64'(ipgp_pkg::STORE_BYTES))
                begin
                    // planes in order, so overlapping slabs see earlier planes
                    for (int p = 0; p < int'(nplanes); p++)
                    begin
                        rd[p] = store_bit_rmw(slab * 64'(p) + addr, item.pos_x, wr,
                                              item.pixel_value[p]);
                    end
                    done = 1'b1;
                end
            end
        end
        res.ok         = done;
        res.read_value = (done && !wr) ? rd : '0;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------

    function automatic logic [31:0] layout_field(logic [2:0] idx);
        case (idx)
            ipgp_pkg::REG_FORMAT:      return 32'(layout.image_format);
            ipgp_pkg::REG_PIXEL_SIZE:  return 32'(layout.pixel_size_code);
            ipgp_pkg::REG_LINE_BYTES:  return 32'(layout.line_bytes);
            ipgp_pkg::REG_WIDTH:       return 32'(layout.image_width);
            ipgp_pkg::REG_HEIGHT:      return 32'(layout.image_height);
            ipgp_pkg::REG_MSB_FIRST:   return 32'(layout.msb_first);
            ipgp_pkg::REG_PLANE_COUNT: return 32'(layout.plane_count);
            default:                   return '0;
        endcase
    endfunction

    // write one register, mirror it, then read it back
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        logic [31:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            ipgp_pkg::REG_FORMAT:      layout.image_format    = val[1:0];
            ipgp_pkg::REG_PIXEL_SIZE:  layout.pixel_size_code = val[1:0];
            ipgp_pkg::REG_LINE_BYTES:  layout.line_bytes      = val[15:0];
            ipgp_pkg::REG_WIDTH:       layout.image_width     = val[12:0];
            ipgp_pkg::REG_HEIGHT:      layout.image_height    = val[12:0];
            ipgp_pkg::REG_MSB_FIRST:   layout.msb_first       = val[0];
            ipgp_pkg::REG_PLANE_COUNT: layout.plane_count     = val[5:0];
            default:                   ;
        endcase
        // readback: setup with pwrite low, then access
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== layout_field(idx))
        begin
            report_mismatch("register readback", layout_field(idx), got);
        end
    endtask

    // drain outstanding transactions so the unit is idle
    task automatic finish_phase();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // program a whole layout, only once the unit is idle
    task automatic set_layout(logic [1:0] fmt, logic [1:0] psz, int lb, int w, int h,
                              logic msb, int planes);
        finish_phase();
        write_reg(ipgp_pkg::REG_FORMAT,      32'(fmt));
        write_reg(ipgp_pkg::REG_PIXEL_SIZE,  32'(psz));
        write_reg(ipgp_pkg::REG_LINE_BYTES,  32'(lb));
        write_reg(ipgp_pkg::REG_WIDTH,       32'(w));
        write_reg(ipgp_pkg::REG_HEIGHT,      32'(h));
        write_reg(ipgp_pkg::REG_MSB_FIRST,   32'(msb));
        write_reg(ipgp_pkg::REG_PLANE_COUNT, 32'(planes));
        n_layouts++;
    endtask

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic ipgp_pkg::req_t pixel_req(logic act, int x, int y, logic [31:0] v);
        ipgp_pkg::req_t item;
        item.action      = act;
        item.pos_x       = x[11:0];
        item.pos_y       = y[11:0];
        item.pixel_value = v;
        return item;
    endfunction

    // one request transaction; valid stays high into the next one when no gap
    task automatic send_pixel(ipgp_pkg::req_t item);
        int             gap;
        ipgp_pkg::rsp_t want;
        gap = tx_idle ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        want = predict_pixel(item);
        expected_rsp.push_back(want);
        n_items++;
        n_by_format[layout.image_format]++;
        if (item.action == ACT_WRITE)
            n_writes++;
        if (!want.ok)
            n_refused++;
    endtask

    // ------------------------------------------------------------------------
    // response side: random stalls plus the long hold-off, counted here
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else if (hold_len > 0)
            begin
                rsp_stall  <= 1'b1;
                stall_left = hold_len - 1;
                hold_len   = 0;
            end
            else if (rx_idle)
            begin
                stall_left = pick_gap();
                rsp_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    // every response is compared with the oldest prediction
    always @(posedge clk)
    begin
        ipgp_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                report_mismatch("unexpected response", '0, rsp.read_value);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, rsp.read_value);
                if (rsp.ok !== want.ok)
                    report_mismatch("ok", 32'(want.ok), 32'(rsp.ok));
                n_checked++;
            end
        end
    end

    // ends a hung run: counts cycles in which no transaction moves
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // random stimulus helpers
    // ------------------------------------------------------------------------

    // mostly inside the image, some just past the edge, some anywhere
    function automatic logic [11:0] pick_coord(int lim);
        int r, c;
        r = $urandom_range(0, 99);
        if (r < 80 && lim > 0)
            c = $urandom_range(0, lim - 1);
        else if (r < 90)
            c = lim + $urandom_range(0, 2);
        else
            c = $urandom_range(0, 4095);
        return (c > 4095) ? 12'd4095 : c[11:0];
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r == 2)
            return 32'd1;
        else
            return $urandom();
    endfunction

    // random traffic in the current layout; writes are often read back
    task automatic send_random(int count);
        int             weff, heff, sent;
        ipgp_pkg::req_t item;
        weff = (layout.image_width  > ipgp_pkg::MAX_DIM) ? ipgp_pkg::MAX_DIM
                                                          : int'(layout.image_width);
        heff = (layout.image_height > ipgp_pkg::MAX_DIM) ? ipgp_pkg::MAX_DIM
                                                          : int'(layout.image_height);
        sent = 0;
        while (sent < count)
        begin
            item.action      = 1'($urandom_range(0, 1));
            item.pos_x       = pick_coord(weff);
            item.pos_y       = pick_coord(heff);
            item.pixel_value = pick_value();
            send_pixel(item);
            sent++;
            if (item.action == ACT_WRITE && sent < count && $urandom_range(0, 9) < 4)
            begin
                item.action      = ACT_READ;
                item.pixel_value = $urandom();
                send_pixel(item);
                sent++;
            end
        end
    endtask

    // layout sized so that the image mostly fits the store, sometimes not
    task automatic pick_random_layout();
        logic [1:0] fmt, psz;
        logic       msb;
        int         r, planes, w, weff, bits, need, lb, used, hmax, h;
        r   = $urandom_range(0, 19);
        fmt = (r < 8)  ? ipgp_pkg::FMT_PACKED :
              (r < 12) ? ipgp_pkg::FMT_BITMAP :
              (r < 19) ? ipgp_pkg::FMT_PLANES : FMT_UNUSED;
        psz = 2'($urandom_range(0, 3));
        msb = 1'($urandom_range(0, 1));
        r   = $urandom_range(0, 9);
        planes = (r == 0) ? 0 : (r == 1) ? 63 : (r == 2) ? 32 : $urandom_range(1, 8);
        r   = $urandom_range(0, 9);
        w   = (r < 6) ? $urandom_range(1, 64) :
              (r < 9) ? $urandom_range(1, 4096) : $urandom_range(4097, 8191);
        weff = (w > ipgp_pkg::MAX_DIM) ? ipgp_pkg::MAX_DIM : w;
        bits = 1;
        if (fmt == ipgp_pkg::FMT_PACKED)
            bits = (psz == ipgp_pkg::PSZ_8)  ? 8  :
                   (psz == ipgp_pkg::PSZ_16) ? 16 :
                   (psz == ipgp_pkg::PSZ_32) ? 32 : 1;
        need = (weff * bits + 7) / 8;
        lb   = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
                                            : need + $urandom_range(0, 4);
        used = (fmt == ipgp_pkg::FMT_PLANES && planes > 1) ?
               ((planes > ipgp_pkg::MAX_PLANES) ? ipgp_pkg::MAX_PLANES : planes) : 1;
        hmax = (lb == 0) ? ipgp_pkg::MAX_DIM : ipgp_pkg::STORE_BYTES / (lb * used);
        if (hmax > ipgp_pkg::MAX_DIM)
            hmax = ipgp_pkg::MAX_DIM;
        if (hmax < 1)
            hmax = 1;
        r = $urandom_range(0, 19);
        h = (r == 0) ? 8191 : (r < 3) ? hmax + $urandom_range(1, 8) : $urandom_range(1, hmax);
        set_layout(fmt, psz, lb, w, h, msb, planes);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset layout has zero width, so everything is refused
    task automatic test_reset_defaults();
        send_pixel(pixel_req(ACT_WRITE, 0, 0, 32'hFFFF_FFFF));
        send_pixel(pixel_req(ACT_READ,  0, 0, 32'h0));
    endtask

    // 32, 16 and 8 bit pixels, corners, out of bounds, narrow writes
    task automatic test_packed_layouts();
        set_layout(ipgp_pkg::FMT_PACKED, ipgp_pkg::PSZ_32, 64, 16, 16, 1'b0, 1);
        send_pixel(pixel_req(ACT_WRITE, 0, 0, 32'hFFFF_FFFF));
        send_pixel(pixel_req(ACT_WRITE, 15, 15, 32'h1234_5678));
        send_pixel(pixel_req(ACT_READ,  15, 15, 32'h0));
        send_pixel(pixel_req(ACT_READ,  16, 0, 32'h0));
        send_pixel(pixel_req(ACT_WRITE, 4095, 4095, 32'hFFFF_FFFF));
        set_layout(ipgp_pkg::FMT_PACKED, ipgp_pkg::PSZ_16, 64, 16, 16, 1'b0, 1);
        send_pixel(pixel_req(ACT_WRITE, 3, 2, 32'hDEAD_BEEF));
        send_pixel(pixel_req(ACT_READ,  3, 2, 32'h0));
        set_layout(ipgp_pkg::FMT_PACKED, ipgp_pkg::PSZ_8, 64, 16, 16, 1'b0, 1);
        send_pixel(pixel_req(ACT_WRITE, 5, 1, 32'h0000_A5C3));
        send_pixel(pixel_req(ACT_READ,  5, 1, 32'h0));
    endtask

    // bitmap with both bit orders, nonzero sets, zero clears, one-bit packed
    task automatic test_bit_order();
        set_layout(ipgp_pkg::FMT_BITMAP, ipgp_pkg::PSZ_32, 2, 16, 2, 1'b1, 1);
        send_pixel(pixel_req(ACT_WRITE, 9, 0, 32'h0000_0100));
        send_pixel(pixel_req(ACT_READ,  9, 0, 32'h0));
        set_layout(ipgp_pkg::FMT_BITMAP, ipgp_pkg::PSZ_32, 2, 16, 2, 1'b0, 1);
        send_pixel(pixel_req(ACT_READ,  9, 0, 32'h0));
        send_pixel(pixel_req(ACT_READ,  14, 0, 32'h0));
        send_pixel(pixel_req(ACT_WRITE, 14, 0, 32'h0));
        set_layout(ipgp_pkg::FMT_PACKED, ipgp_pkg::PSZ_1, 2, 16, 2, 1'b0, 1);
        send_pixel(pixel_req(ACT_READ,  14, 0, 32'h0));
    endtask

    // widest rows and clamped dimensions, accesses running past the store
    task automatic test_store_limits();
        set_layout(ipgp_pkg::FMT_PACKED, ipgp_pkg::PSZ_32, 65535, 8191, 8191, 1'b0, 1);
        send_pixel(pixel_req(ACT_READ,  4095, 0, 32'h0));
        send_pixel(pixel_req(ACT_WRITE, 0, 1, 32'hCAFE_F00D));
        set_layout(ipgp_pkg::FMT_PACKED, ipgp_pkg::PSZ_8, 65535, 8191, 8191, 1'b0, 1);
        send_pixel(pixel_req(ACT_WRITE, 0, 1, 32'h0000_00FF));
        send_pixel(pixel_req(ACT_READ,  0, 1, 32'h0));
    endtask

    // all 32 planes, no planes, and a plane count above the maximum
    task automatic test_plane_layout();
        set_layout(ipgp_pkg::FMT_PLANES, ipgp_pkg::PSZ_32, 2, 16, 8, 1'b0, 32);
        send_pixel(pixel_req(ACT_WRITE, 10, 3, 32'h8000_0001));
        send_pixel(pixel_req(ACT_READ,  10, 3, 32'h0));
        set_layout(ipgp_pkg::FMT_PLANES, ipgp_pkg::PSZ_32, 2, 16, 8, 1'b0, 0);
        send_pixel(pixel_req(ACT_READ,  10, 3, 32'h0));
        set_layout(ipgp_pkg::FMT_PLANES, ipgp_pkg::PSZ_32, 2, 16, 8, 1'b0, 63);
        send_pixel(pixel_req(ACT_READ,  10, 3, 32'h0));
    endtask

    task automatic test_unused_format();
        set_layout(FMT_UNUSED, ipgp_pkg::PSZ_32, 64, 16, 16, 1'b0, 1);
        send_pixel(pixel_req(ACT_READ, 0, 0, 32'h0));
    endtask

    // random layouts; some phases run with no idling on one or both sides
    task automatic test_random_layouts(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            tx_idle = (ph % 3 != 0);
            rx_idle = (ph % 4 != 1);
            pick_random_layout();
            send_random(per_phase);
        end
    endtask

    // long response hold-off while requests keep coming, slowest layout
    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        set_layout(ipgp_pkg::FMT_PLANES, ipgp_pkg::PSZ_32, 4, 32, 16, 1'b1, 32);
        hold_len = 400;
        send_random(40);
        tx_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // mirror starts in the reset state
        layout = '{image_format: ipgp_pkg::FMT_PACKED, pixel_size_code: ipgp_pkg::PSZ_32,
                   line_bytes: 16'd0, image_width: 13'd0, image_height: 13'd0,
                   msb_first: 1'b0, plane_count: 6'd1};
        foreach (image_mem[i])
            image_mem[i] = 8'h00;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_packed_layouts();
        test_bit_order();
        test_store_limits();
        test_plane_layout();
        test_unused_format();
        test_random_layouts(12, 150);
        test_output_backpressure();

        // wait out every response, then a little more for stray ones
        finish_phase();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d transactions over %0d layouts: %0d writes, %0d refused",
                 n_items, n_layouts, n_writes, n_refused);
        $display("by format: packed %0d, bitmap %0d, planes %0d, unused %0d; %0d checked",
                 n_by_format[0], n_by_format[1], n_by_format[2], n_by_format[3], n_checked);
        if (mismatches == 0 && expected_rsp.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> image_pixel_get_put.f
hdl/ipgp_pkg.sv
hdl/ipgp_ram.sv
hdl/ipgp_cfg.sv
hdl/image_pixel_get_put.sv
tb/image_pixel_get_put_tb.sv
